// File: rtl/wbss_pkg.sv
// shared types and constants for the wildcard byte signature scanner
package wbss_pkg;

  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int HW_MAX     = 16;
  localparam int LM1_W      = 4;
  localparam int LEN_W      = 5;
  localparam int Q_DEPTH    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW   = 3'd0,
    REG_PATTERN_HIGH  = 3'd1,
    REG_CARE_MASK     = 3'd2,
    REG_PATTERN_LEN   = 3'd3,
    REG_RESULT_OFFSET = 3'd4,
    REG_EXTRA_COUNT   = 3'd5,
    REG_LOW_ADDRESS   = 3'd6,
    REG_MODE_FLAGS    = 3'd7
  } cfg_reg_t;

  // settings as seen by the datapath
  typedef struct packed {
    logic [8*HW_MAX-1:0] pattern;
    logic [HW_MAX-1:0]   care;
    logic [LM1_W-1:0]    lm1;
    logic [ADDR_W-1:0]   adj;
  } cfg_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic              hit;
    logic              last;
    logic [ADDR_W-1:0] rel_addr;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic take;
    logic take_last;
  } back_status_t;

endpackage

// File: rtl/wbss_cfg.sv
// configuration registers with clamped length and precomputed address adjustment
module wbss_cfg #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [wbss_pkg::CFG_DATA_W-1:0] wr_data,
  output wbss_pkg::cfg_t                  cfg
);
  import wbss_pkg::*;

  localparam int EFF_MAX = (PATTERN_MAX < HW_MAX) ? PATTERN_MAX : HW_MAX;

  logic [CFG_DATA_W-1:0] pattern_low_r, pattern_high_r;
  logic [HW_MAX-1:0]     care_r;
  logic [LM1_W-1:0]      lm1_r, lm1_wr;
  logic [ADDR_W-1:0]     offset_r, extra_r, low_r, adj_r, adj_nxt;
  logic [1:0]            mode_r;
  logic [LEN_W-1:0]      len_wr;

  // length 0 acts as 1, above the maximum acts as the maximum
  always_comb begin
    len_wr = wr_data[LEN_W-1:0];
    if (len_wr == '0) begin
      lm1_wr = '0;
    end else if (len_wr > LEN_W'(EFF_MAX)) begin
      lm1_wr = LM1_W'(EFF_MAX - 1);
    end else begin
      lm1_wr = LM1_W'(len_wr - LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r  <= '0;
      pattern_high_r <= '0;
      care_r         <= '1;
      lm1_r          <= '0;
      offset_r       <= '0;
      extra_r        <= '0;
      low_r          <= '0;
      mode_r         <= '0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_PATTERN_LOW:   pattern_low_r  <= wr_data;
        REG_PATTERN_HIGH:  pattern_high_r <= wr_data;
        REG_CARE_MASK:     care_r         <= wr_data[HW_MAX-1:0];
        REG_PATTERN_LEN:   lm1_r          <= lm1_wr;
        REG_RESULT_OFFSET: offset_r       <= wr_data[ADDR_W-1:0];
        REG_EXTRA_COUNT:   extra_r        <= wr_data[ADDR_W-1:0];
        REG_LOW_ADDRESS:   low_r          <= wr_data[ADDR_W-1:0];
        REG_MODE_FLAGS:    mode_r         <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  // registered adjustment, ready before any later byte reaches the back end
  always_comb begin
    adj_nxt = offset_r + (mode_r[0] ? extra_r : '0) - (mode_r[1] ? low_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_r <= '0;
    end else begin
      adj_r <= adj_nxt;
    end
  end

  assign cfg.pattern = {pattern_high_r, pattern_low_r};
  assign cfg.care    = care_r;
  assign cfg.lm1     = lm1_r;
  assign cfg.adj     = adj_r;

endmodule

// File: rtl/wbss_front.sv
// front end: byte window, position counter and masked pattern compare
module wbss_front #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [7:0]                  byte_value,
  input  logic [wbss_pkg::ADDR_W-1:0] region_base,
  input  logic                        last_in_region,
  input  wbss_pkg::cfg_t              cfg,
  output wbss_pkg::item_t             item
);
  import wbss_pkg::*;

  localparam int EFF_MAX = (PATTERN_MAX < HW_MAX) ? PATTERN_MAX : HW_MAX;
  localparam int WIN_D   = (EFF_MAX > 1) ? EFF_MAX - 1 : 1;

  logic [7:0]        win_r [WIN_D];
  logic [7:0]        hist  [EFF_MAX];
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [7:0]        sel;
  logic              ok;

  // hist[k] is the byte k positions back, the incoming byte at k = 0
  always_comb begin
    hist[0] = byte_value;
    for (int i = 1; i < EFF_MAX; i++) begin
      hist[i] = win_r[i-1];
    end
  end

  // pattern byte j lines up with the byte lm1 - j positions back
  always_comb begin
    ok  = 1'b1;
    sel = '0;
    for (int j = 0; j < EFF_MAX; j++) begin
      sel = '0;
      for (int k = 0; k < EFF_MAX; k++) begin
        if (LEN_W'(j + k) == {1'b0, cfg.lm1}) begin
          sel = hist[k];
        end
      end
      if (LEN_W'(j) <= {1'b0, cfg.lm1} && cfg.care[j] && sel != cfg.pattern[8*j +: 8]) begin
        ok = 1'b0;
      end
    end
  end

  assign item.hit      = ok && (pos_r >= ADDR_W'(cfg.lm1));
  assign item.last     = last_in_region;
  assign item.rel_addr = region_base + pos_r - ADDR_W'(cfg.lm1);

  always_comb begin
    if (last_in_region) begin
      pos_nxt = '0;
    end else if (pos_r == '1) begin
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= byte_value;
      for (int i = 1; i < WIN_D; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

endmodule

// File: rtl/wbss_queue.sv
// short queue of classified bytes between front and back end
module wbss_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  wbss_pkg::item_t       push_item,
  input  logic                  pop,
  output wbss_pkg::item_t       head,
  output wbss_pkg::q_status_t   status
);
  import wbss_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t            mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign status.full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/wbss_back.sv
// back end: keeps the first match of a region and issues the region result
module wbss_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wbss_pkg::item_t              head,
  input  logic                         q_empty,
  input  logic [wbss_pkg::ADDR_W-1:0]  adj,
  input  logic                         out_pop,
  output logic                         q_pop,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [wbss_pkg::ADDR_W-1:0]  out_addr,
  output wbss_pkg::back_status_t       status
);
  import wbss_pkg::*;

  logic              seen_r, seen_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              valid_r, valid_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic              slot_free, take, eff_seen;
  logic [ADDR_W-1:0] eff_addr;

  assign slot_free = !valid_r || out_pop;
  assign take      = !q_empty && (!head.last || slot_free);
  assign eff_seen  = seen_r || head.hit;
  assign eff_addr  = seen_r ? addr_r : head.rel_addr + adj;

  always_comb begin
    seen_nxt  = seen_r;
    addr_nxt  = addr_r;
    valid_nxt = valid_r && !out_pop;
    found_nxt = found_r;
    oaddr_nxt = oaddr_r;
    if (take) begin
      if (head.last) begin
        valid_nxt = 1'b1;
        found_nxt = eff_seen;
        oaddr_nxt = eff_seen ? eff_addr : '0;
        seen_nxt  = 1'b0;
      end else begin
        seen_nxt = eff_seen;
        addr_nxt = eff_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      seen_r  <= seen_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    found_r <= found_nxt;
    oaddr_r <= oaddr_nxt;
  end

  assign q_pop            = take;
  assign out_valid        = valid_r;
  assign out_found        = found_r;
  assign out_addr         = oaddr_r;
  assign status.take      = take;
  assign status.take_last = take && head.last;

endmodule

// File: rtl/wildcard_byte_signature_scanner_core.sv
// the result for a region's last byte is shown in the cycle after that byte is taken
// throughput: one byte per cycle unless in_full, as the masked compare is combinational
// a two-entry queue separates front and back; the result sits in an output register
// reset (synchronous, rst_n low) restores register defaults and clears position,
// match state, queue and output; the byte window is not cleared
module wildcard_byte_signature_scanner_core #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_byte_value,
  input  logic [wbss_pkg::ADDR_W-1:0]     in_region_base,
  input  logic                            in_last_in_region,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_found,
  output logic [wbss_pkg::ADDR_W-1:0]     out_match_address,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wbss_pkg::*;

  cfg_t         cfg;
  item_t        front_item, q_head;
  q_status_t    q_st;
  back_status_t back_st;
  logic         accept, q_pop, out_valid, pop_ok;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_st.full;
  assign in_full   = q_st.full;
  assign out_empty = !out_valid;
  assign pop_ok    = out_pop && out_valid;

  wbss_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  wbss_front #(.PATTERN_MAX(PATTERN_MAX)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .byte_value     (in_byte_value),
    .region_base    (in_region_base),
    .last_in_region (in_last_in_region),
    .cfg            (cfg),
    .item           (front_item)
  );

  wbss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_st)
  );

  wbss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_st.empty),
    .adj       (cfg.adj),
    .out_pop   (pop_ok),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_found (out_found),
    .out_addr  (out_match_address),
    .status    (back_st)
  );

  // a region without a match reports address zero
  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_found |-> out_match_address == '0)
    else $error("result without match carries nonzero address");

  // a region end only leaves the queue when the output register can take it
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.take_last |-> out_empty || out_pop)
    else $error("region result would overwrite a pending transaction");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.take_last |=> !out_empty)
    else $error("region end taken but no result shown");

  // the back end never pulls from an empty queue
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.take |-> !q_st.empty)
    else $error("back end took from empty queue");

endmodule
